// ----- sv/rmq_pkg.sv -----
// Shared widths, sideband struct and saturation helper for the
// rotation-matrix-to-quaternion pipeline. No dependencies.
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int ARG_W  = DATA_WIDTH + 3;                   // signed branch argument
  localparam int RAD_RW = ARG_W - 1 + FRAC_BITS;
  localparam int RAD_W  = RAD_RW + (RAD_RW % 2);            // radicand, even width
  localparam int ROOT_W = RAD_W / 2;                        // floor root width
  localparam int RND_W  = ROOT_W + 1;                       // rounded root width
  localparam int REM_W  = ROOT_W + 2;                       // root remainder width
  localparam int MAG_W  = DATA_WIDTH + 1;                   // |off-diagonal sum|
  localparam int NUM_A  = MAG_W + FRAC_BITS;
  localparam int NUM_W  = ((NUM_A > RND_W) ? NUM_A : RND_W) + 1;
  localparam int DIV_W  = RND_W + 1;                        // divisor 2*S

  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_M00   = 2'd1;
  localparam logic [1:0] CASE_M11   = 2'd2;
  localparam logic [1:0] CASE_M22   = 2'd3;

  typedef struct packed {
    logic [1:0]            sel;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

  // saturate a magnitude with sign to the signed DATA_WIDTH range
  function automatic logic [DATA_WIDTH-1:0] sat_mag(input logic [NUM_W-1:0] m,
                                                   input logic neg);
    logic [NUM_W-1:0] lim;
    logic [NUM_W-1:0] negv;
    begin
      lim  = NUM_W'({1'b1, {(DATA_WIDTH-1){1'b0}}});
      negv = ~m + NUM_W'(1);
      if (neg) begin
        sat_mag = (m > lim) ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : negv[DATA_WIDTH-1:0];
      end else begin
        sat_mag = (m > lim - NUM_W'(1)) ? {1'b0, {(DATA_WIDTH-1){1'b1}}}
                                          : m[DATA_WIDTH-1:0];
      end
    end
  endfunction

endpackage

// ----- sv/rmq_front.sv -----
// Branch selection, argument and off-diagonal sums: one register stage.
// Uses rmq_pkg.
module rmq_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 valid_in,
  input  logic [8:0][rmq_pkg::DATA_WIDTH-1:0]  m,
  output logic                                 valid_out,
  output logic [rmq_pkg::RAD_W-1:0]            rad,
  output rmq_pkg::side_t                       side
);
  localparam int AW = rmq_pkg::ARG_W;
  localparam int MW = rmq_pkg::MAG_W;

  logic signed [AW-1:0] e [9];
  logic signed [AW-1:0] tr, arg, one;
  logic signed [AW-1:0] d [3];
  logic [1:0]           sel;
  logic                 valid_r;
  logic [rmq_pkg::RAD_W-1:0] rad_r;
  rmq_pkg::side_t       side_r, side_nxt;
  logic [rmq_pkg::RAD_W-1:0] rad_nxt;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = AW'($signed(m[k]));
    end
    one = AW'(1) <<< rmq_pkg::FRAC_BITS;
    tr  = e[0] + e[4] + e[8];
    if (tr > 0) begin
      sel = rmq_pkg::CASE_TRACE;
      arg = tr + one;
      d[0] = e[7] - e[5]; d[1] = e[2] - e[6]; d[2] = e[3] - e[1];
    end else if (e[0] >= e[4] && e[0] >= e[8]) begin
      sel = rmq_pkg::CASE_M00;
      arg = one + e[0] - e[4] - e[8];
      d[0] = e[3] + e[1]; d[1] = e[2] + e[6]; d[2] = e[7] - e[5];
    end else if (e[4] > e[8]) begin
      sel = rmq_pkg::CASE_M11;
      arg = one + e[4] - e[0] - e[8];
      d[0] = e[3] + e[1]; d[1] = e[7] + e[5]; d[2] = e[2] - e[6];
    end else begin
      sel = rmq_pkg::CASE_M22;
      arg = one + e[8] - e[0] - e[4];
      d[0] = e[2] + e[6]; d[1] = e[7] + e[5]; d[2] = e[3] - e[1];
    end
    side_nxt.sel   = sel;
    side_nxt.degen = (arg <= 0);
    for (int k = 0; k < 3; k++) begin
      side_nxt.neg[k] = d[k][AW-1];
      side_nxt.mag[k] = d[k][AW-1] ? MW'(-d[k]) : MW'(d[k]);
    end
    rad_nxt = side_nxt.degen ? '0
            : rmq_pkg::RAD_W'({arg[AW-2:0], {rmq_pkg::FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_out = valid_r;
  assign rad       = rad_r;
  assign side      = side_r;
endmodule

// ----- sv/rmq_sqrt.sv -----
// Pipelined digit-by-digit square root, two radicand bits per stage, then a
// round-to-nearest stage. Uses rmq_pkg.
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_in,
  input  logic [rmq_pkg::RAD_W-1:0]   rad,
  input  rmq_pkg::side_t              side_in,
  output logic                        valid_out,
  output logic [rmq_pkg::RND_W-1:0]   root,
  output rmq_pkg::side_t              side_out
);
  localparam int N  = rmq_pkg::ROOT_W;
  localparam int RW = rmq_pkg::RAD_W;
  localparam int QW = rmq_pkg::REM_W;

  logic [RW-1:0]  rad_r  [N+1];
  logic [N-1:0]   root_r [N+1];
  logic [QW-1:0]  rem_r  [N+1];
  logic           vld_r  [N+1];
  rmq_pkg::side_t side_r [N+1];

  logic                      vout_r;
  logic [rmq_pkg::RND_W-1:0] rnd_r;
  rmq_pkg::side_t            sout_r;

  assign rad_r[0]  = rad;
  assign root_r[0] = '0;
  assign rem_r[0]  = '0;
  assign vld_r[0]  = valid_in;
  assign side_r[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [QW-1:0] r2, trial;
    assign r2    = {rem_r[i][QW-3:0], rad_r[i][RW-1 -: 2]};
    assign trial = {root_r[i], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i+1]  <= rad_r[i] << 2;
        side_r[i+1] <= side_r[i];
        if (r2 >= trial) begin
          rem_r[i+1]  <= r2 - trial;
          root_r[i+1] <= {root_r[i][N-2:0], 1'b1};
        end else begin
          rem_r[i+1]  <= r2;
          root_r[i+1] <= {root_r[i][N-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= vld_r[N];
    end
  end

  // remainder is v - root^2; round up when it exceeds root
  always_ff @(posedge clk) begin
    if (en) begin
      sout_r <= side_r[N];
      rnd_r  <= (rem_r[N] > QW'(root_r[N])) ? rmq_pkg::RND_W'(root_r[N]) + 1'b1
                                            : rmq_pkg::RND_W'(root_r[N]);
    end
  end

  assign valid_out = vout_r;
  assign root      = rnd_r;
  assign side_out  = sout_r;
endmodule

// ----- sv/rmq_div.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage:
// q = (mag*ONE + S) / (2S). Uses rmq_pkg.
module rmq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_in,
  input  logic [rmq_pkg::RND_W-1:0]   root,
  input  rmq_pkg::side_t              side_in,
  output logic                        valid_out,
  output logic [2:0][rmq_pkg::NUM_W-1:0] quo,
  output logic [rmq_pkg::RND_W-1:0]   root_out,
  output rmq_pkg::side_t              side_out
);
  localparam int N  = rmq_pkg::NUM_W;
  localparam int DW = rmq_pkg::DIV_W;

  logic [2:0][N-1:0]  num_r [N+1];
  logic [2:0][N-1:0]  q_r   [N+1];
  logic [2:0][DW-1:0] rem_r [N+1];
  logic [DW-1:0]      dvs_r [N+1];
  logic [rmq_pkg::RND_W-1:0] s_r [N+1];
  logic               vld_r [N+1];
  rmq_pkg::side_t     side_r [N+1];

  // stage 0: form numerators and divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[0][k] <= (N'(side_in.mag[k]) << rmq_pkg::FRAC_BITS) + N'(root);
      end
      q_r[0]    <= '0;
      rem_r[0]  <= '0;
      dvs_r[0]  <= {root, 1'b0};
      s_r[0]    <= root;
      side_r[0] <= side_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [2:0][DW:0] r2;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k] = {rem_r[i][k], num_r[i][k][N-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[i+1]  <= dvs_r[i];
        s_r[i+1]    <= s_r[i];
        side_r[i+1] <= side_r[i];
        for (int k = 0; k < 3; k++) begin
          num_r[i+1][k] <= num_r[i][k] << 1;
          if (r2[k] >= {1'b0, dvs_r[i]}) begin
            rem_r[i+1][k] <= DW'(r2[k] - {1'b0, dvs_r[i]});
            q_r[i+1][k]   <= {q_r[i][k][N-2:0], 1'b1};
          end else begin
            rem_r[i+1][k] <= DW'(r2[k]);
            q_r[i+1][k]   <= {q_r[i][k][N-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_out = vld_r[N];
  assign quo       = q_r[N];
  assign root_out  = s_r[N];
  assign side_out  = side_r[N];
endmodule

// ----- sv/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to unit quaternion, trace-or-largest-diagonal method.
// Stages: 1 branch stage, 16 root stages, 1 rounding stage,
// 1 divider setup, 32 quotient stages (one bit each), 1 output register.
// Throughput one matrix per cycle; a stalled output freezes the whole pipe.
// Reset (rst_n low, synchronous) clears the valid bits only.
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22, 16 b each
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // qx qy qz qw, 16 b each
  output logic [2:0]   out_tuser   // case_taken[1:0], degenerate
);
  localparam int DW = rmq_pkg::DATA_WIDTH;

  logic en;
  logic [8:0][DW-1:0] mat;

  logic                          f_vld;
  logic [rmq_pkg::RAD_W-1:0]     f_rad;
  rmq_pkg::side_t                f_side;
  logic                          s_vld;
  logic [rmq_pkg::RND_W-1:0]     s_root;
  rmq_pkg::side_t                s_side;
  logic                          d_vld;
  logic [2:0][rmq_pkg::NUM_W-1:0] d_quo;
  logic [rmq_pkg::RND_W-1:0]     d_root;
  rmq_pkg::side_t                d_side;

  logic              out_valid_r;
  logic [63:0]       out_data_r, out_data_nxt;
  logic [2:0]        out_user_r, out_user_nxt;

  // whole pipe advances together; holds while the result waits
  assign en        = ~out_valid_r | out_tready;
  assign in_tready = en;
  assign mat       = in_tdata;

  rmq_front u_front (
    .clk, .rst_n, .en,
    .valid_in (in_tvalid & en),
    .m        (mat),
    .valid_out(f_vld),
    .rad      (f_rad),
    .side     (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .valid_in (f_vld),
    .rad      (f_rad),
    .side_in  (f_side),
    .valid_out(s_vld),
    .root     (s_root),
    .side_out (s_side)
  );

  rmq_div u_div (
    .clk, .rst_n, .en,
    .valid_in (s_vld),
    .root     (s_root),
    .side_in  (s_side),
    .valid_out(d_vld),
    .quo      (d_quo),
    .root_out (d_root),
    .side_out (d_side)
  );

  // final stage: saturate, steer components into x y z w by branch
  always_comb begin
    logic [rmq_pkg::RND_W-1:0] half;
    logic [DW-1:0] dg;
    logic [DW-1:0] o [3];
    logic [3:0][DW-1:0] q;
    half = (d_root + 1'b1) >> 1;
    dg   = (half > rmq_pkg::RND_W'({(DW-1){1'b1}})) ? {1'b0, {(DW-1){1'b1}}}
                                                   : DW'(half);
    for (int k = 0; k < 3; k++) begin
      o[k] = rmq_pkg::sat_mag(d_quo[k], d_side.neg[k]);
    end
    case (d_side.sel)
      rmq_pkg::CASE_TRACE: q = {dg,   o[2], o[1], o[0]};
      rmq_pkg::CASE_M00:   q = {o[2], o[1], o[0], dg};
      rmq_pkg::CASE_M11:   q = {o[2], o[1], dg,   o[0]};
      default:             q = {o[2], dg,   o[1], o[0]};
    endcase
    out_data_nxt = d_side.degen ? '0 : q;
    out_user_nxt = {d_side.degen, d_side.sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule

// ----- bench/rotation_matrix_to_quaternion_tb.sv -----
// Testbench for rotation_matrix_to_quaternion: streams 3x3 matrices, predicts each
// quaternion with an in-bench fixed-point model and compares beat by beat.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;

  localparam int W        = rmq_pkg::DATA_WIDTH;
  localparam int WDOG_MAX = 4000;
  localparam int N_RANDOM = 1130;

  typedef logic signed [W-1:0] elem_t;

  typedef struct packed {
    elem_t [8:0] m;            // index 0 = r00 ... 8 = r22
  } matrix_t;

  // same bit order as {out_tuser, out_tdata}
  typedef struct packed {
    logic       degen;
    logic [1:0] sel;
    elem_t      qw, qz, qy, qx;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_send = 1'b0;
  int      errors = 0;
  int      n_checked = 0;
  int      n_degen = 0;
  int      branch_cnt[4] = '{0, 0, 0, 0};
  int      wdog = 0;

  function automatic longint clamp_q(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // integer square root rounded to nearest
  function automatic longint isqrt_near(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (longint'(1) <<< b)) * (r | (longint'(1) <<< b)) <= v)
        r = r | (longint'(1) <<< b);
    if (v - r * r > r) r++;
    return r;
  endfunction

  // d * ONE / (2s), half away from zero
  function automatic longint off_diag(longint d, longint s);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< rmq_pkg::FRAC_BITS) + s) / (2 * s);
    return (d < 0) ? -q : q;
  endfunction

  function automatic quat_t quat_from_matrix(matrix_t mt);
    longint a[9];
    longint q[4];
    longint tr, arg, s, d0, d1, d2, one;
    int diag, o0, o1, o2;
    quat_t res;
    one = longint'(1) <<< rmq_pkg::FRAC_BITS;
    for (int i = 0; i < 9; i++) a[i] = longint'(mt.m[i]);
    tr = a[0] + a[4] + a[8];
    q = '{0, 0, 0, 0};
    if (tr > 0) begin
      res.sel = rmq_pkg::CASE_TRACE; arg = tr + one;
      diag = 3; o0 = 0; o1 = 1; o2 = 2;
      d0 = a[7] - a[5]; d1 = a[2] - a[6]; d2 = a[3] - a[1];
    end else if (a[0] >= a[4] && a[0] >= a[8]) begin
      res.sel = rmq_pkg::CASE_M00; arg = one + a[0] - a[4] - a[8];
      diag = 0; o0 = 1; o1 = 2; o2 = 3;
      d0 = a[3] + a[1]; d1 = a[2] + a[6]; d2 = a[7] - a[5];
    end else if (a[4] > a[8]) begin
      res.sel = rmq_pkg::CASE_M11; arg = one + a[4] - a[0] - a[8];
      diag = 1; o0 = 0; o1 = 2; o2 = 3;
      d0 = a[3] + a[1]; d1 = a[7] + a[5]; d2 = a[2] - a[6];
    end else begin
      res.sel = rmq_pkg::CASE_M22; arg = one + a[8] - a[0] - a[4];
      diag = 2; o0 = 0; o1 = 1; o2 = 3;
      d0 = a[2] + a[6]; d1 = a[7] + a[5]; d2 = a[3] - a[1];
    end
    res.degen = (arg <= 0);
    if (!res.degen) begin
      s = isqrt_near(arg <<< rmq_pkg::FRAC_BITS);
      q[diag] = clamp_q((s + 1) >>> 1);
      q[o0] = clamp_q(off_diag(d0, s));
      q[o1] = clamp_q(off_diag(d1, s));
      q[o2] = clamp_q(off_diag(d2, s));
    end
    res.qx = elem_t'(q[0]); res.qy = elem_t'(q[1]);
    res.qz = elem_t'(q[2]); res.qw = elem_t'(q[3]);
    return res;
  endfunction

  // Driver: one beat per accepted handshake, random idle per phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (!in_tvalid || in_tready) begin
        if (pending_mats.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_mats[0];
          expected_quats.push_back(quat_from_matrix(pending_mats[0]));
          void'(pending_mats.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each accepted result beat.
  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (expected_quats.size() == 0) begin
          $display("%0t unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = expected_quats.pop_front();
          n_checked++;
          if (want.degen) n_degen++;
          branch_cnt[want.sel]++;
          if (got.qx !== want.qx)
            $display("%0t qx exp %h got %h", $time, want.qx, got.qx);
          if (got.qy !== want.qy)
            $display("%0t qy exp %h got %h", $time, want.qy, got.qy);
          if (got.qz !== want.qz)
            $display("%0t qz exp %h got %h", $time, want.qz, got.qz);
          if (got.qw !== want.qw)
            $display("%0t qw exp %h got %h", $time, want.qw, got.qw);
          if (got.sel !== want.sel)
            $display("%0t case_taken exp %0d got %0d", $time, want.sel, got.sel);
          if (got.degen !== want.degen)
            $display("%0t degenerate exp %b got %b", $time, want.degen, got.degen);
          if (got !== want) errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else if (rst_n) wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired, %0d results outstanding", expected_quats.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic elem_t rnd_elem();
    return elem_t'($urandom);
  endfunction

  // Roughly orthonormal matrix from a random quaternion, plus small noise.
  function automatic matrix_t rnd_rotation();
    real x, y, z, w, n, f;
    real r[9];
    matrix_t mt;
    x = $urandom_range(2000) - 1000.0; y = $urandom_range(2000) - 1000.0;
    z = $urandom_range(2000) - 1000.0; w = $urandom_range(2000) - 1000.0;
    n = $sqrt(x*x + y*y + z*z + w*w) + 1e-9;
    x /= n; y /= n; z /= n; w /= n;
    r[0] = 1 - 2*(y*y + z*z); r[1] = 2*(x*y - z*w); r[2] = 2*(x*z + y*w);
    r[3] = 2*(x*y + z*w); r[4] = 1 - 2*(x*x + z*z); r[5] = 2*(y*z - x*w);
    r[6] = 2*(x*z - y*w); r[7] = 2*(y*z + x*w); r[8] = 1 - 2*(x*x + y*y);
    f = 1 << rmq_pkg::FRAC_BITS;
    for (int i = 0; i < 9; i++)
      mt.m[i] = elem_t'($rtoi(r[i] * f) + int'($urandom_range(8)) - 4);
    return mt;
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      matrix_t mt;
      if ($urandom_range(99) < 75) mt = rnd_rotation();
      else for (int k = 0; k < 9; k++) mt.m[k] = rnd_elem();
      pending_mats.push_back(mt);
    end
    wait (pending_mats.size() == 0);
  endtask

  initial begin
    matrix_t mt;
    elem_t one;
    one = elem_t'(1 <<< rmq_pkg::FRAC_BITS);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity and each branch, saturation, extremes.
    mt.m = '{one, 0, 0, 0, one, 0, 0, 0, one};  pending_mats.push_back(mt);
    mt.m = '{-one, 0, 0, 0, -one, 0, 0, 0, one}; pending_mats.push_back(mt);
    mt.m = '{-one, 0, 0, 0, one, 0, 0, 0, -one}; pending_mats.push_back(mt);
    mt.m = '{one, 0, 0, 0, -one, 0, 0, 0, -one}; pending_mats.push_back(mt);
    mt.m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one}; pending_mats.push_back(mt);
    mt.m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; pending_mats.push_back(mt);
    mt.m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; pending_mats.push_back(mt);
    mt.m = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; pending_mats.push_back(mt);
    mt.m = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
             16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; pending_mats.push_back(mt);
    mt.m = '{0, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, 16'sh8000,
             16'sh8000, 16'sh7fff, -16'sh0001}; pending_mats.push_back(mt);
    mt.m = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
             16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555}; pending_mats.push_back(mt);
    mt.m = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
             16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}; pending_mats.push_back(mt);
    mt.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; pending_mats.push_back(mt);
    for (int i = 0; i < 6; i++) pending_mats.push_back(rnd_rotation());
    wait (pending_mats.size() == 0);

    run_phase(330, 0, 0);
    run_phase(200, 79, 0);
    run_phase(200, 0, 79);
    // sender holds off until the pipe drains
    hold_send = 1'b1;
    wait (expected_quats.size() == 0 && !in_tvalid);
    hold_send = 1'b0;
    run_phase(200, 33, 33);
    run_phase(200, 0, 0);

    wait (expected_quats.size() == 0);
    repeat (80) @(posedge clk);
    $display("checked %0d quaternions: %0d trace, %0d m00, %0d m11, %0d m22 branch",
             n_checked, branch_cnt[0], branch_cnt[1], branch_cnt[2], branch_cnt[3]);
    $display("%0d degenerate matrices, %0d mismatching beats", n_degen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
bench/rotation_matrix_to_quaternion_tb.sv
